// ----- src/nsht_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsht_pkg
// Shared types and constants of the nearest segment hit test.
// ----------------------------------------------------------------------------
package nsht_pkg;

	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;
	localparam int DIST_BITS   = 50;
	localparam int ID_BITS     = 16;
	localparam int RAD_BITS    = 10;
	localparam int IDX_BITS    = 2;
	localparam int CFG_BITS    = 16;
	// difference of two coordinates
	localparam int DIFF_BITS   = COORD_BITS + 1;
	// product of two differences, sum of two products
	localparam int PROD_BITS   = 2 * DIFF_BITS;
	localparam int SUM_BITS    = PROD_BITS + 1;
	// t in Q1.F, up to and including the value 1.0
	localparam int T_BITS      = T_FRAC_BITS + 1;
	// error component w*2^F - t*d
	localparam int ERR_BITS    = DIFF_BITS + T_FRAC_BITS + 2;
	localparam int CNT_BITS    = $clog2(T_FRAC_BITS + 1);

	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	localparam logic [IDX_BITS-1:0] REG_CURSOR_X    = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_CURSOR_Y    = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_PICK_RADIUS = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_PROD,
		ST_SETUP,
		ST_DIV,
		ST_ERR,
		ST_SQ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic diff;
		logic prod;
		logic setup;
		logic div_step;
		logic err;
		logic sq;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic last_seg;
	} status_t;

endpackage
`default_nettype wire

// ----- src/nsht_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsht_seg_if / nsht_res_if
// Valid/ready channels for segments and results.
// ----------------------------------------------------------------------------
interface nsht_seg_if;
	logic                                    valid;
	logic                                    ready;
	logic [nsht_pkg::ID_BITS-1:0]            segment_id;
	logic signed [nsht_pkg::COORD_BITS-1:0]  start_x;
	logic signed [nsht_pkg::COORD_BITS-1:0]  start_y;
	logic signed [nsht_pkg::COORD_BITS-1:0]  end_x;
	logic signed [nsht_pkg::COORD_BITS-1:0]  end_y;
	logic                                    last_segment;
	modport source (output valid, segment_id, start_x, start_y, end_x, end_y,
		last_segment, input ready);
	modport sink (input valid, segment_id, start_x, start_y, end_x, end_y,
		last_segment, output ready);
endinterface

interface nsht_res_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [nsht_pkg::ID_BITS-1:0]      best_id;
	logic [nsht_pkg::DIST_BITS-1:0]    best_dist_sq;
	modport source (output valid, found, best_id, best_dist_sq, input ready);
	modport sink (input valid, found, best_id, best_dist_sq, output ready);
endinterface
`default_nettype wire

// ----- src/nsht_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsht_ctrl
// Sequencer: steps one segment through the datapath.
// ----------------------------------------------------------------------------
module nsht_ctrl
	import nsht_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire logic    res_busy,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_next = ST_DIFF;
			ST_DIFF:  state_next = ST_PROD;
			ST_PROD:  state_next = ST_SETUP;
			ST_SETUP: state_next = ST_DIV;
			ST_DIV:   if (status.div_last) state_next = ST_ERR;
			ST_ERR:   state_next = ST_SQ;
			ST_SQ:    state_next = ST_DONE;
			ST_DONE:  if (!(status.last_seg && res_busy)) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIFF:  cmd.diff = 1'b1;
			ST_PROD:  cmd.prod = 1'b1;
			ST_SETUP: cmd.setup = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_ERR:   cmd.err = 1'b1;
			ST_SQ:    cmd.sq = 1'b1;
			ST_DONE:  cmd.done = !(status.last_seg && res_busy);
			default:  cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/nsht_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsht_dp
// Distance datapath, restoring divider, running best and result register.
// ----------------------------------------------------------------------------
module nsht_dp
	import nsht_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	input  wire logic signed [COORD_BITS-1:0]  cur_x,
	input  wire logic signed [COORD_BITS-1:0]  cur_y,
	input  wire logic [RAD_BITS-1:0]           radius,
	input  wire logic [ID_BITS-1:0]            in_id,
	input  wire logic signed [COORD_BITS-1:0]  in_ax,
	input  wire logic signed [COORD_BITS-1:0]  in_ay,
	input  wire logic signed [COORD_BITS-1:0]  in_bx,
	input  wire logic signed [COORD_BITS-1:0]  in_by,
	input  wire logic                          in_last,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic                               res_found,
	output logic [ID_BITS-1:0]                 res_id,
	output logic [DIST_BITS-1:0]               res_dist
);

	logic [ID_BITS-1:0]                id_q;
	logic                              last_q;
	logic signed [COORD_BITS-1:0]      ax_q, ay_q, bx_q, by_q;
	logic signed [DIFF_BITS-1:0]       wx_q, wy_q, dx_q, dy_q;
	logic signed [PROD_BITS-1:0]       p0_q, p1_q, p2_q, p3_q;
	logic [SUM_BITS-1:0]               len_q, rem_q;
	logic [T_BITS-1:0]                 t_q;
	logic [CNT_BITS-1:0]               cnt_q;
	logic signed [ERR_BITS-1:0]        ex_q, ey_q;
	logic [DIST_BITS-1:0]              d_q;
	logic [2*RAD_BITS-1:0]             rsq_q;
	logic [DIST_BITS-1:0]              best_d_q;
	logic [ID_BITS-1:0]                best_id_q;
	logic                              best_f_q;

	logic signed [SUM_BITS-1:0]        len_s, dot_s;
	logic [SUM_BITS:0]                 rem_sh;
	logic signed [ERR_BITS-1:0]        tdx, tdy;
	logic [ERR_BITS-1:0]               mx, my;
	logic [DIST_BITS-1:0]              sqx, sqy;
	logic [DIST_BITS:0]                dsum;
	logic [DIST_BITS-1:0]              limit;
	logic                              better;

	// floor(m^2 / 2^F) saturated; m below 2^(ERR_BITS-1)
	function automatic logic [DIST_BITS-1:0] sq_scaled(input logic [ERR_BITS-1:0] m);
		logic [2*ERR_BITS-1:0] p;
		logic [2*ERR_BITS-1:0] s;
		p = m * m;
		s = p >> T_FRAC_BITS;
		if (s > {{(2*ERR_BITS-DIST_BITS){1'b0}}, DIST_MAX}) begin
			return DIST_MAX;
		end
		return s[DIST_BITS-1:0];
	endfunction

	assign len_s  = SUM_BITS'(p2_q) + SUM_BITS'(p3_q);
	assign dot_s  = SUM_BITS'(p0_q) + SUM_BITS'(p1_q);
	assign rem_sh = {rem_q, 1'b0};
	// full-width t * d for the error vector
	assign tdx    = $signed({1'b0, t_q}) * dx_q;
	assign tdy    = $signed({1'b0, t_q}) * dy_q;
	assign mx     = ex_q[ERR_BITS-1] ? -ex_q : ex_q;
	assign my     = ey_q[ERR_BITS-1] ? -ey_q : ey_q;
	assign sqx    = sq_scaled(mx);
	assign sqy    = sq_scaled(my);
	assign dsum   = {1'b0, sqx} + {1'b0, sqy};
	assign limit  = DIST_BITS'({rsq_q, {T_FRAC_BITS{1'b0}}});
	assign better = (d_q < limit) && (d_q < best_d_q);

	assign status.div_last = (cnt_q == CNT_BITS'(1)) || (cnt_q == '0);
	assign status.last_seg = last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= in_id;
			last_q <= in_last;
			ax_q   <= in_ax;
			ay_q   <= in_ay;
			bx_q   <= in_bx;
			by_q   <= in_by;
		end
		if (cmd.diff) begin
			wx_q  <= DIFF_BITS'(cur_x) - DIFF_BITS'(ax_q);
			wy_q  <= DIFF_BITS'(cur_y) - DIFF_BITS'(ay_q);
			dx_q  <= DIFF_BITS'(bx_q) - DIFF_BITS'(ax_q);
			dy_q  <= DIFF_BITS'(by_q) - DIFF_BITS'(ay_q);
			rsq_q <= radius * radius;
		end
		if (cmd.prod) begin
			p0_q <= wx_q * dx_q;
			p1_q <= wy_q * dy_q;
			p2_q <= dx_q * dx_q;
			p3_q <= dy_q * dy_q;
		end
		// pick t = 0, t = 1.0 or arm the divider
		if (cmd.setup) begin
			len_q <= len_s;
			rem_q <= dot_s;
			if (len_s == '0 || dot_s <= 0) begin
				t_q   <= '0;
				cnt_q <= '0;
			end else if (dot_s >= len_s) begin
				t_q   <= T_BITS'(1) << T_FRAC_BITS;
				cnt_q <= '0;
			end else begin
				t_q   <= '0;
				cnt_q <= CNT_BITS'(T_FRAC_BITS);
			end
		end
		// one quotient bit per cycle
		if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (rem_sh >= {1'b0, len_q}) begin
				rem_q <= SUM_BITS'(rem_sh - {1'b0, len_q});
				t_q   <= {t_q[T_BITS-2:0], 1'b1};
			end else begin
				rem_q <= SUM_BITS'(rem_sh);
				t_q   <= {t_q[T_BITS-2:0], 1'b0};
			end
		end
		if (cmd.err) begin
			ex_q <= (ERR_BITS'(wx_q) <<< T_FRAC_BITS) - tdx;
			ey_q <= (ERR_BITS'(wy_q) <<< T_FRAC_BITS) - tdy;
		end
		if (cmd.sq) begin
			d_q <= dsum[DIST_BITS] ? DIST_MAX : dsum[DIST_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_d_q  <= DIST_MAX;
			best_id_q <= '0;
			best_f_q  <= 1'b0;
			res_valid <= 1'b0;
			res_found <= 1'b0;
			res_id    <= '0;
			res_dist  <= DIST_MAX;
		end else begin
			if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			if (cmd.done) begin
				if (last_q) begin
					res_valid <= 1'b1;
					res_found <= best_f_q || better;
					res_id    <= better ? id_q : (best_f_q ? best_id_q : '0);
					res_dist  <= better ? d_q : (best_f_q ? best_d_q : DIST_MAX);
					best_d_q  <= DIST_MAX;
					best_id_q <= '0;
					best_f_q  <= 1'b0;
				end else if (better) begin
					best_d_q  <= d_q;
					best_id_q <= id_q;
					best_f_q  <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/nearest_segment_hit_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_segment_hit_test
// Picks the segment nearest to a cursor within a pick radius.
// ----------------------------------------------------------------------------
// Usage:
//   seg: one segment per transfer (id, endpoints, last_segment flag).
//   res: one transfer per scan, after the segment flagged last: found flag,
//        best id (0 if none) and squared distance in Q34.16 (all ones if none).
//   Config: cfg_we/cfg_index/cfg_data write cursor_x, cursor_y, pick_radius
//        while the block is idle.
// Steps: a segment passes load, differences, products, setup, one
//   restoring-divider step per bit of t when the divider runs (a single
//   divider state when t is 0 or 1.0), error vector, squares, compare.
//   The divider loop sets the rate.
// Reset: cursor at 0, radius 5, running best cleared; a scan ends with the
//   result and the running best returns to the cleared state.
// Stall: a result waits in the output register; the next segment is taken
//   and processed meanwhile, and only the next scan's final segment holds
//   until the previous result has been taken.
// ----------------------------------------------------------------------------
module nearest_segment_hit_test
	import nsht_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_BITS-1:0]  cfg_data,
	nsht_seg_if.sink                  seg,
	nsht_res_if.source                res
);

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [RAD_BITS-1:0]          radius_q;
	cmd_t                         cmd;
	status_t                      status;

	// configuration registers; other indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			radius_q <= RAD_BITS'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CURSOR_X:    cur_x_q  <= cfg_data;
				REG_CURSOR_Y:    cur_y_q  <= cfg_data;
				REG_PICK_RADIUS: radius_q <= cfg_data[RAD_BITS-1:0];
				default:         ;
			endcase
		end
	end

	nsht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (seg.valid),
		.in_ready (seg.ready),
		.res_busy (res.valid),
		.status   (status),
		.cmd      (cmd)
	);

	nsht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cur_x     (cur_x_q),
		.cur_y     (cur_y_q),
		.radius    (radius_q),
		.in_id     (seg.segment_id),
		.in_ax     (seg.start_x),
		.in_ay     (seg.start_y),
		.in_bx     (seg.end_x),
		.in_by     (seg.end_y),
		.in_last   (seg.last_segment),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_found (res.found),
		.res_id    (res.best_id),
		.res_dist  (res.best_dist_sq)
	);

	// a result with no hit carries id 0 and all-ones distance
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.found) |-> (res.best_id == '0 && res.best_dist_sq == DIST_MAX))
		else $error("empty result carries a payload");

	// a hit lies strictly inside the radius
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.found) |->
		(res.best_dist_sq < DIST_BITS'({(2*RAD_BITS)'(radius_q) * (2*RAD_BITS)'(radius_q),
			{T_FRAC_BITS{1'b0}}})))
		else $error("hit outside radius");

	// no segment is taken while one is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(seg.valid && seg.ready) |=> !seg.ready)
		else $error("segment accepted while busy");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest segment hit test. It runs a table of
// directed segments first, some with the result typed in, then random scans
// under several cursor and radius settings. Both handshake sides idle at
// random, save in gapless phases. Each result is checked field by field
// against its typed value or a local model of distance, threshold and first-wins pick.
// ----------------------------------------------------------------------------
module tb_top;
	import nsht_pkg::*;

	localparam logic [IDX_BITS-1:0] REG_SPARE = 2'd3; // not a register, writes drop
	localparam int DRAIN_CYCLES = 40;   // settle time once every pick is in
	localparam int STALL_LIMIT  = 2000; // cycles without any transfer
	localparam int N_PHASES     = 8;
	localparam int PHASE_ITEMS  = 142;

	typedef struct packed {
		logic                  found;
		logic [ID_BITS-1:0]    best_id;
		logic [DIST_BITS-1:0]  best_dist_sq;
	} pick_t;

	typedef struct packed {
		logic [ID_BITS-1:0]           id;
		logic signed [COORD_BITS-1:0] ax, ay, bx, by;
		logic                         last;
	} segment_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] cx, cy;
		logic [RAD_BITS-1:0]          rad;
		segment_t                     s;
		bit                           typed;
		pick_t                        want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	nsht_seg_if seg ();
	nsht_res_if res ();

	nearest_segment_hit_test u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seg       (seg.sink),
		.res       (res.source)
	);

	always #2 clk = ~clk;

	// Local copy of the configuration and of the running pick.
	logic signed [COORD_BITS-1:0] cur_x, cur_y;
	logic [RAD_BITS-1:0]          cur_rad;
	logic [DIST_BITS-1:0]         scan_best_dist;
	logic [ID_BITS-1:0]           scan_best_id;
	logic                         scan_found;

	pick_t pending_picks[$];
	int errors = 0;
	int n_segments = 0;
	int n_picks = 0;
	int n_hits = 0;
	int stall_cnt = 0;
	bit no_idle = 1'b0; // phases without gaps on either side

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// Squared distance from the cursor to the segment, Q34.16, saturated.
	function automatic logic [DIST_BITS-1:0] seg_dist_sq(input segment_t s);
		longint wx, wy, dx, dy, len, dot, t, ex, ey, rem;
		logic [127:0] mx, my, sum;
		wx = longint'(cur_x) - longint'(s.ax);
		wy = longint'(cur_y) - longint'(s.ay);
		dx = longint'(s.bx) - longint'(s.ax);
		dy = longint'(s.by) - longint'(s.ay);
		len = dx * dx + dy * dy;
		dot = wx * dx + wy * dy;
		if (len == 0 || dot <= 0) begin
			t = 0;
		end else if (dot >= len) begin
			t = longint'(1) << T_FRAC_BITS;
		end else begin
			// restoring division, one quotient bit per step
			rem = dot;
			t = 0;
			for (int i = 0; i < T_FRAC_BITS; i++) begin
				rem = rem << 1;
				t = t << 1;
				if (rem >= len) begin
					rem -= len;
					t |= 1;
				end
			end
		end
		ex = (wx << T_FRAC_BITS) - t * dx;
		ey = (wy << T_FRAC_BITS) - t * dy;
		mx = (ex < 0) ? -ex : ex;
		my = (ey < 0) ? -ey : ey;
		sum = ((mx * mx) >> T_FRAC_BITS) + ((my * my) >> T_FRAC_BITS);
		return (sum > DIST_MAX) ? DIST_MAX : sum[DIST_BITS-1:0];
	endfunction

	// Fold one segment into the running pick; return 1 with the result on a last one.
	function automatic bit fold_segment(input segment_t s, output pick_t p);
		logic [DIST_BITS-1:0] d, limit;
		d = seg_dist_sq(s);
		limit = DIST_BITS'(cur_rad) * DIST_BITS'(cur_rad) << 16;
		if (d < limit && d < scan_best_dist) begin
			scan_best_dist = d;
			scan_best_id = s.id;
			scan_found = 1'b1;
		end
		p = '{scan_found, scan_found ? scan_best_id : '0,
			scan_found ? scan_best_dist : DIST_MAX};
		if (!s.last)
			return 0;
		scan_best_dist = DIST_MAX;
		scan_best_id = '0;
		scan_found = 1'b0;
		return 1;
	endfunction

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	// Write all registers; upper bits of the radius word carry junk that must drop.
	task automatic set_config(input logic signed [COORD_BITS-1:0] cx,
			input logic signed [COORD_BITS-1:0] cy, input logic [RAD_BITS-1:0] rad);
		write_reg(REG_CURSOR_X, cx);
		write_reg(REG_CURSOR_Y, cy);
		write_reg(REG_PICK_RADIUS, {6'($urandom), rad});
		write_reg(REG_SPARE, 16'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_x = cx;
		cur_y = cy;
		cur_rad = rad;
	endtask

	// Hold off the sender until every pick is in, then let the pipe settle.
	task automatic drain();
		@(negedge clk);
		seg.valid <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Drive one segment and hold it until the transfer; queue its result, if any.
	task automatic send_segment(input segment_t s, input bit typed, input pick_t want);
		int gap;
		pick_t p;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			@(negedge clk);
			seg.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		seg.valid <= 1'b1;
		seg.segment_id <= s.id;
		seg.start_x <= s.ax;
		seg.start_y <= s.ay;
		seg.end_x <= s.bx;
		seg.end_y <= s.by;
		seg.last_segment <= s.last;
		do @(posedge clk); while (!seg.ready);
		n_segments++;
		if (fold_segment(s, p))
			pending_picks.push_back(typed ? want : p);
	endtask

	function automatic logic signed [COORD_BITS-1:0] near_coord(
			input logic signed [COORD_BITS-1:0] c, input int span);
		return c + COORD_BITS'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic segment_t random_segment(input bit last);
		segment_t s;
		int span;
		span = int'(cur_rad) + 8;
		s.id = 16'($urandom);
		s.last = last;
		case ($urandom_range(0, 9))
			0, 1: begin
				// anywhere on the screen
				s.ax = 16'($urandom); s.ay = 16'($urandom);
				s.bx = 16'($urandom); s.by = 16'($urandom);
			end
			2: begin
				// degenerate: a single point
				s.ax = near_coord(cur_x, span); s.ay = near_coord(cur_y, span);
				s.bx = s.ax; s.by = s.ay;
			end
			3: begin
				// long segment passing near the cursor
				s.ax = near_coord(cur_x, 30000); s.ay = near_coord(cur_y, span);
				s.bx = near_coord(cur_x, 30000); s.by = near_coord(cur_y, span);
			end
			default: begin
				s.ax = near_coord(cur_x, span); s.ay = near_coord(cur_y, span);
				s.bx = near_coord(cur_x, 2 * span); s.by = near_coord(cur_y, 2 * span);
			end
		endcase
		return s;
	endfunction

	// Result side: random ready gaps, check each transfer against the oldest pick.
	initial begin
		int gap;
		pick_t want;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				res.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			n_picks++;
			if (pending_picks.size() == 0) begin
				report("unexpected result", res.best_id, 0);
			end else begin
				want = pending_picks.pop_front();
				if (res.found)
					n_hits++;
				if (res.found !== want.found)
					report("found", res.found, want.found);
				if (res.best_id !== want.best_id)
					report("best_id", res.best_id, want.best_id);
				if (res.best_dist_sq !== want.best_dist_sq)
					report("best_dist_sq", res.best_dist_sq, want.best_dist_sq);
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((seg.valid && seg.ready) || (res.valid && res.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	dir_row_t rows[$];

	initial begin
		segment_t s;
		int left;
		pick_t none;
		none = '{1'b0, '0, DIST_MAX};
		seg.valid = 1'b0;
		seg.segment_id = '0;
		seg.start_x = '0;
		seg.start_y = '0;
		seg.end_x = '0;
		seg.end_y = '0;
		seg.last_segment = 1'b0;
		cur_x = '0;
		cur_y = '0;
		cur_rad = 10'd5;
		scan_best_dist = DIST_MAX;
		scan_best_id = '0;
		scan_found = 1'b0;

		// Directed rows: cursor x/y, radius, segment, and a typed result where obvious.
		// Reset settings first: cursor at the origin, radius 5.
		// point at distance exactly 5: not strictly inside
		rows.push_back('{0, 0, 5, '{16'd7, 3, 4, 3, 4, 1}, 1, none});
		// point at distance 3
		rows.push_back('{0, 0, 5, '{16'd9, 3, 0, 3, 0, 1}, 1, '{1, 16'd9, 50'd589824}});
		// cursor on the segment
		rows.push_back('{0, 0, 5, '{16'h1234, -10, 0, 10, 0, 1}, 1, '{1, 16'h1234, 50'd0}});
		// far corner edge, top id
		rows.push_back('{0, 0, 5, '{16'hFFFF, -32768, -32768, 32767, -32768, 1}, 1, none});
		// tie: the earlier of two equal segments wins
		rows.push_back('{0, 0, 5, '{16'd1, 0, 2, 5, 2, 0}, 0, none});
		rows.push_back('{0, 0, 5, '{16'd2, 0, 2, 5, 2, 1}, 1, '{1, 16'd1, 50'd262144}});
		// interior projection with a fractional t
		rows.push_back('{0, 0, 5, '{16'd3, -3, 1, 7, 4, 1}, 0, none});
		// projection beyond the end point
		rows.push_back('{0, 0, 5, '{16'd4, -5, -5, -2, -1, 1}, 0, none});
		// two-segment scan, far one then near one
		rows.push_back('{0, 0, 5, '{16'd5, 32767, 32767, -32768, 32767, 0}, 0, none});
		rows.push_back('{0, 0, 5, '{16'd6, 1, 1, 2, 2, 1}, 0, none});
		// zero radius: nothing qualifies, even a hit through the cursor
		rows.push_back('{0, 0, 0, '{16'd8, -10, 0, 10, 0, 1}, 1, none});
		// cursor in a corner, widest radius
		rows.push_back('{-32768, -32768, 1023,
			'{16'd10, -32768, -32768, 32767, 32767, 1}, 1, '{1, 16'd10, 50'd0}});
		rows.push_back('{-32768, -32768, 1023,
			'{16'd11, 32767, 32767, 32767, 32767, 1}, 0, none});
		rows.push_back('{32767, -32768, 1023,
			'{16'd12, -32768, 32767, -32768, 32767, 1}, 0, none});
		rows.push_back('{32767, -32768, 1023,
			'{16'd13, 32767, -32760, 32760, -32768, 1}, 0, none});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the table; apply a new setting only when the row asks for one.
		foreach (rows[i]) begin
			if (rows[i].cx != cur_x || rows[i].cy != cur_y || rows[i].rad != cur_rad) begin
				drain();
				set_config(rows[i].cx, rows[i].cy, rows[i].rad);
			end
			send_segment(rows[i].s, rows[i].typed, rows[i].want);
		end

		// Random scans under a series of settings, extremes among them.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			no_idle = (ph % 3 == 2);
			case (ph)
				0: set_config(0, 0, 10'd5);
				1: set_config(-32768, 32767, 10'd1023);
				2: set_config(32767, -32768, 10'd0);
				3: set_config(16'($urandom), 16'($urandom), 10'd1);
				default: set_config(16'($urandom), 16'($urandom),
					10'($urandom_range(0, 60)));
			endcase
			left = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (left == 0)
					left = $urandom_range(1, 6);
				left--;
				s = random_segment(left == 0 || k == PHASE_ITEMS - 1);
				if (s.last)
					left = 0;
				send_segment(s, 1'b0, none);
			end
		end

		@(negedge clk);
		seg.valid <= 1'b0;
		drain();
		$display("ran %0d segments in %0d directed rows and %0d random phases",
			n_segments, rows.size(), N_PHASES);
		$display("checked %0d scan results, %0d of them with a hit", n_picks, n_hits);
		if (errors == 0 && pending_picks.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_picks.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
